>>> hw/rtl/rth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants and the table generator step for the rotating tabulation
// hash core.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int ROWS_DEFAULT = 32;
  localparam int COLS         = 256;
  localparam int COL_W        = 8;
  localparam int HASH_W       = 64;

  localparam logic [HASH_W-1:0] SEED = 64'hdeadbeefcafebabe;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  // One step of the xorshift64 generator.
  function automatic logic [HASH_W-1:0] xorshift64(input logic [HASH_W-1:0] s);
    logic [HASH_W-1:0] t;
    t = s ^ (s << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rth_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rth_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // The read data holds while no read is issued.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rotating_tabulation_hash_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotating_tabulation_hash_core
// Streams message bytes through a rotating tabulation hash and emits the
// 64-bit hash at each end of message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one beat per byte: data_byte,
//   has_byte (the byte is real) and end_of_message (emit the hash). A beat
//   with has_byte low and end_of_message high closes a message without a byte.
//   Output channel (out_valid / out_ready) carries one hash_value beat per
//   end of message, in order.
//   After reset the table RAM is filled with the xorshift64 sequence, one
//   word per cycle, so in_ready stays low until all ROWS*256 words are
//   written (8192 at the default of 32 rows). The hash state starts at zero.
//   Throughput is one input beat per cycle unless stalled: the table RAM
//   serves one read per cycle and the accumulator XOR completes in the cycle
//   after the read. An accepted end-of-message beat goes through stage 1 into
//   the output register, where the hash sits; new beats keep being accepted
//   while it waits. Only when a second end-of-message beat reaches the
//   accumulate stage while the output register is still full does in_ready
//   drop, until the receiver takes the pending hash.
// ----------------------------------------------------------------------------
module rotating_tabulation_hash_core
  import rth_pkg::*;
#(
  parameter int ROWS = ROWS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [COL_W-1:0]  data_byte,
  input  wire logic              has_byte,
  input  wire logic              end_of_message,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [HASH_W-1:0] hash_value
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = ROW_W + COL_W;

  // Table fill after reset.
  logic              filling;
  logic [ADDR_W-1:0] fill_addr;
  logic [HASH_W-1:0] gen_state;
  logic [HASH_W-1:0] gen_word;

  assign gen_word = xorshift64(gen_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
      gen_state <= SEED;
    end else if (filling) begin
      gen_state <= gen_word;
      fill_addr <= fill_addr + ADDR_W'(1);
      if (fill_addr == ADDR_W'(DEPTH - 1)) begin
        filling <= 1'b0;
      end
    end
  end

  // Stage 0: accept a beat, issue the table read and advance the row.
  logic             accept;
  logic             stall;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [HASH_W-1:0] table_word;

  assign accept   = in_valid && in_ready;
  assign in_ready = !filling && !stall;

  always_comb begin
    row_next = row;
    if (accept) begin
      if (has_byte) begin
        row_next = (row == ROW_W'(ROWS - 1)) ? '0 : row + ROW_W'(1);
      end
      if (end_of_message) begin
        row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

  rth_ram #(
    .WIDTH(HASH_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (filling),
    .wr_addr(fill_addr),
    .wr_data(gen_word),
    .rd_en  (accept && has_byte),
    .rd_addr({row, data_byte}),
    .rd_data(table_word)
  );

  // Stage 1: fold the table word into the accumulator. The stage holds when
  // it carries an end of message and the output register cannot take it; the
  // RAM read data holds too, because no beat is accepted meanwhile.
  logic              s1_valid;
  logic              s1_has;
  logic              s1_eom;
  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] acc_next;
  logic              out_load;

  assign stall    = s1_valid && s1_eom && out_valid && !out_ready;
  assign acc_next = s1_has ? (acc ^ table_word) : acc;
  assign out_load = s1_valid && s1_eom && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_has   <= 1'b0;
      s1_eom   <= 1'b0;
      acc      <= '0;
    end else if (!stall) begin
      s1_valid <= accept;
      s1_has   <= has_byte;
      s1_eom   <= end_of_message;
      if (s1_valid) begin
        acc <= s1_eom ? '0 : acc_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash_value <= acc_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rth_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_checker
// Port-level assertions for the rotating tabulation hash core.
// ----------------------------------------------------------------------------
module rth_checker
  import rth_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              end_of_message,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [HASH_W-1:0] hash_value
);

  // The table fill keeps the input closed right after reset.
  a_fill_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // A stalled hash beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("hash beat changed while stalled");

  // An accepted end of message shows a hash after stage 1.
  a_eom_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_message |-> ##2 out_valid)
    else $error("no hash two cycles after end of message");

  // A hash never appears without an accepted end of message before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && end_of_message, 2))
    else $error("hash beat without end of message");

endmodule

bind rotating_tabulation_hash_core rth_checker u_rth_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .end_of_message(end_of_message),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hash_value    (hash_value)
);
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotating_tabulation_hash_core. A local copy of the
// xorshift64 table and of the hash state predicts the hash of every message.
// The bench runs a few directed messages, then about 950 random input beats
// with random idling on both channels, and checks each hash beat in order.
// ----------------------------------------------------------------------------
module tb;
  import rth_pkg::*;

  localparam int NUM_ROWS    = ROWS_DEFAULT;
  localparam int FILL_CYCLES = NUM_ROWS * COLS;
  // The table fill after reset keeps in_ready low while it writes the table.
  // No other correct stretch without any beat comes close to that.
  localparam int WATCHDOG_LIMIT = 4 * FILL_CYCLES;
  localparam int RANDOM_BEATS   = 950;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [COL_W-1:0]  data_byte;
  logic              has_byte;
  logic              end_of_message;
  logic              out_valid;
  logic              out_ready;
  logic [HASH_W-1:0] hash_value;

  rotating_tabulation_hash_core #(
    .ROWS(NUM_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hash_value(hash_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted block state: the random table and the running hash.
  logic [HASH_W-1:0] tab_word [0:FILL_CYCLES-1];
  logic [HASH_W-1:0] acc;
  int                row_ptr;
  logic [HASH_W-1:0] expected_hashes [$];

  int   errors;
  int   beats_counted;
  bit   no_idle;
  bit   hash_taken;
  int   rx_wait;
  int   idle_cycles;
  logic [HASH_W-1:0] want;

  // One step of the table generator: shifts left, right, left.
  function automatic logic [HASH_W-1:0] next_table_word(input logic [HASH_W-1:0] s);
    logic [HASH_W-1:0] t;
    t = s ^ (s << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

  task automatic build_table();
    logic [HASH_W-1:0] s;
    s = SEED;
    for (int i = 0; i < FILL_CYCLES; i++) begin
      s = next_table_word(s);
      tab_word[i] = s;
    end
    acc     = '0;
    row_ptr = 0;
  endtask

  // Folds one accepted input beat into the predicted state. The byte goes in
  // before the end mark, so a beat that carries both ends with its own byte.
  function automatic void fold_beat(input logic [COL_W-1:0] b, input logic hb,
                                    input logic eom);
    if (hb) begin
      acc ^= tab_word[row_ptr * COLS + int'(b)];
      row_ptr = (row_ptr == NUM_ROWS - 1) ? 0 : row_ptr + 1;
    end
    if (eom) begin
      expected_hashes.push_back(acc);
      acc     = '0;
      row_ptr = 0;
    end
  endfunction

  // Idle cycles before the next beat on either side. Burst phases use none.
  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Sends one input beat: optional idle cycles with valid low, then valid
  // high with the payload held until the block takes it. The next call (or
  // the end of the run) decides at the following falling edge whether valid
  // drops, so valid is never lowered and raised within one time step.
  task automatic send_beat(input logic [COL_W-1:0] b, input logic hb, input logic eom);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    fold_beat(b, hb, eom);
    beats_counted++;
  endtask

  // Sends a message of len bytes. With merge_end the last byte carries the
  // end mark; otherwise a separate end-only beat closes it. Ignored beats
  // (no byte, no end) are scattered in at the given percentage.
  task automatic send_message(input int len, input bit merge_end, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(COL_W'($urandom), 1'b0, 1'b0);
      send_beat(COL_W'($urandom), 1'b1, merge_end && (i == len - 1));
    end
    if (!merge_end || len == 0)
      send_beat(COL_W'($urandom), 1'b0, 1'b1);
  endtask

  // Output side: the receiver stalls a fresh number of cycles after every
  // hash beat it takes.
  always @(negedge clk) begin
    if (hash_taken) begin
      hash_taken = 1'b0;
      rx_wait    = draw_wait();
    end
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every hash beat is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      hash_taken = 1'b1;
      if (expected_hashes.size() == 0) begin
        $display("%0t: hash_value %h arrived with no hash outstanding",
                 $time, hash_value);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        if (hash_value !== want) begin
          $display("%0t: hash_value mismatch: expected %h, actual %h",
                   $time, want, hash_value);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // An end-only beat straight after reset hashes the empty message to zero,
  // and a second one right after it does the same.
  task automatic test_empty_message();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // Smallest and largest byte values and alternating bit patterns, each
  // message closed by its last byte.
  task automatic test_byte_extremes();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hAA, 1'b1, 1'b0);
    send_beat(8'h55, 1'b1, 1'b1);
  endtask

  // Beats with neither a byte nor an end must leave the hash and the row
  // alone, whatever data_byte holds. The message then closes with an
  // end-only beat whose data byte must be ignored too.
  task automatic test_ignored_beats();
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b1);
  endtask

  // Ends in consecutive cycles with no idling, so that a second hash meets
  // a full output register.
  task automatic test_back_to_back_ends();
    no_idle = 1'b1;
    send_beat(8'h3C, 1'b1, 1'b1);
    send_beat(8'hC3, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h99, 1'b1, 1'b1);
    no_idle = 1'b0;
  endtask

  // Random messages. Most are short; some straddle one or two full passes
  // over the rows so that the row wraps, and a few are long. About one
  // message in four runs with no idling on either side.
  task automatic test_random_messages();
    int len;
    int start_beats;
    start_beats = beats_counted;
    while (beats_counted - start_beats < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(NUM_ROWS - 1, NUM_ROWS + 1);
        2:       len = $urandom_range(2 * NUM_ROWS - 1, 2 * NUM_ROWS + 1);
        3:       len = $urandom_range(70, 120);
        default: len = $urandom_range(1, 24);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      send_message(len, ($urandom_range(0, 1) == 1), 10);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = '0;
    has_byte       = 1'b0;
    end_of_message = 1'b0;
    out_ready      = 1'b0;
    errors          = 0;
    beats_counted   = 0;
    no_idle         = 1'b0;
    hash_taken      = 1'b0;
    rx_wait         = 0;
    idle_cycles     = 0;
    build_table();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_byte_extremes();
    test_ignored_beats();
    test_back_to_back_ends();
    test_random_messages();

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every predicted hash, then a few cycles more in case the
    // block sends something it should not.
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rth_pkg.sv
hw/rtl/rth_ram.sv
hw/rtl/rotating_tabulation_hash_core.sv
hw/rtl/rth_checker.sv
sim/tb.sv
